// ===== sv/spjq_pkg.sv =====
// ----------------------------------------------------------------------------
// spjq_pkg
// Shared types and constants for the sorted priority job queue.
// ----------------------------------------------------------------------------
package spjq_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int PRIO_W   = 8;
  localparam int TIME_W   = 16;
  localparam int TAG_W    = 5;

  localparam logic OP_INSERT   = 1'b0;
  localparam logic OP_DUMP     = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] tim;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    kind_t  kind;
    logic   status;
    entry_t entry;
    logic   last;
  } res_t;

endpackage

// ===== sv/sorted_priority_job_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_job_queue
// Job table kept in descending priority order, with insert and dump commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel takes one command word. in_tuser selects insert (0) or
//   dump (1); in_tdata carries priority and page count of an insert.
//   out_* channel returns result words. An insert answers with one ack
//   word (status 1 when the table is full). A dump returns every stored
//   entry in priority order, one word per cycle while out_tready allows,
//   with out_tlast on the final one; an empty table gives a single
//   empty-marker word. An insert walks the RAM backward from the tail,
//   one entry per cycle, shifting each lower-priority entry up one place
//   until the new job is placed, and then answers with its ack word.
//   One command is in work at a time; in_tready is high only when idle.
//   Reset empties the table; stored entries are not cleared.
//   A stalled receiver holds the output register and pauses the sequencer.
// ----------------------------------------------------------------------------
module sorted_priority_job_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] job_priority, [23:8] job_pages
  input  logic [0:0]  in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [4:0] entry_tag, [12:5] entry_priority,
                                  // [28:13] entry_time, [31:29] zero
  output logic [2:0]  out_tuser,  // [1:0] kind, [2] insert_status
  output logic        out_tlast
);

  logic           res_valid;
  logic           res_ready;
  spjq_pkg::res_t res;

  logic           out_valid_r, out_valid_nxt;
  spjq_pkg::res_t out_res_r, out_res_nxt;

  spjq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser[0]),
    .in_prio   (in_tdata[7:0]),
    .in_pages  (in_tdata[23:8]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.entry.tim, out_res_r.entry.prio, out_res_r.entry.tag};
  assign out_tuser  = {out_res_r.status, out_res_r.kind};
  assign out_tlast  = out_res_r.last;

endmodule

// ===== sv/spjq_ram.sv =====
// ----------------------------------------------------------------------------
// spjq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spjq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/spjq_seq.sv =====
// ----------------------------------------------------------------------------
// spjq_seq
// Sequencer: sorted insert by backward shift, in-order dump, over one RAM.
// ----------------------------------------------------------------------------
module spjq_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [spjq_pkg::PRIO_W-1:0] in_prio,
  input  logic [spjq_pkg::TIME_W-1:0] in_pages,
  output logic                        res_valid,
  input  logic                        res_ready,
  output spjq_pkg::res_t              res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_PLACE,
    S_RESULT,
    S_DOUT
  } state_t;

  state_t                      state_r, state_nxt;
  logic [spjq_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [spjq_pkg::CNT_W-1:0]  pos_r, pos_nxt;
  logic [spjq_pkg::CNT_W-1:0]  dptr_r, dptr_nxt;
  spjq_pkg::entry_t            new_r, new_nxt;
  spjq_pkg::res_t              res_r, res_nxt;

  logic                        wr_en;
  logic [spjq_pkg::ADDR_W-1:0] wr_addr;
  spjq_pkg::entry_t            wr_data;
  logic [spjq_pkg::ADDR_W-1:0] rd_addr;
  spjq_pkg::entry_t            rd_data;

  logic [spjq_pkg::CNT_W-1:0]  cnt_m1, pos_m1, pos_m2, dptr_p1;
  logic [spjq_pkg::CNT_W:0]    tag_sum;
  logic                        dump_last;

  spjq_ram #(
    .WIDTH (spjq_pkg::ENTRY_W),
    .DEPTH (spjq_pkg::CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cnt_m1    = count_r - spjq_pkg::CNT_W'(1);
  assign pos_m1    = pos_r - spjq_pkg::CNT_W'(1);
  assign pos_m2    = pos_r - spjq_pkg::CNT_W'(2);
  assign dptr_p1   = dptr_r + spjq_pkg::CNT_W'(1);
  assign tag_sum   = {1'b0, count_r} + (spjq_pkg::CNT_W + 1)'(1);
  assign dump_last = (dptr_p1 == count_r);

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESULT) || (state_r == S_DOUT);

  always_comb begin
    res = res_r;
    if (state_r == S_DOUT) begin
      res.kind   = spjq_pkg::KIND_ENTRY;
      res.status = spjq_pkg::STATUS_OK;
      res.entry  = rd_data;
      res.last   = dump_last;
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    dptr_nxt  = dptr_r;
    new_nxt   = new_r;
    res_nxt   = res_r;
    wr_en     = 1'b0;
    wr_addr   = pos_r[spjq_pkg::ADDR_W-1:0];
    wr_data   = new_r;
    rd_addr   = dptr_r[spjq_pkg::ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == spjq_pkg::OP_INSERT) begin
            if (count_r == spjq_pkg::CNT_W'(spjq_pkg::CAPACITY)) begin
              res_nxt   = '{kind: spjq_pkg::KIND_ACK, status: spjq_pkg::STATUS_FULL,
                            entry: '0, last: 1'b1};
              state_nxt = S_RESULT;
            end else begin
              new_nxt.tag  = spjq_pkg::TAG_W'(tag_sum);
              new_nxt.prio = in_prio;
              new_nxt.tim  = in_pages;
              pos_nxt      = count_r;
              rd_addr      = cnt_m1[spjq_pkg::ADDR_W-1:0];
              state_nxt    = (count_r == '0) ? S_PLACE : S_CMP;
            end
          end else begin
            if (count_r == '0) begin
              res_nxt   = '{kind: spjq_pkg::KIND_EMPTY, status: spjq_pkg::STATUS_OK,
                            entry: '0, last: 1'b1};
              state_nxt = S_RESULT;
            end else begin
              dptr_nxt  = '0;
              rd_addr   = '0;
              state_nxt = S_DOUT;
            end
          end
        end
      end

      // rd_data holds entry pos-1; shift it up while the new job outranks it
      S_CMP: begin
        if (new_r.prio > rd_data.prio) begin
          wr_en   = 1'b1;
          wr_data = rd_data;
          pos_nxt = pos_m1;
          rd_addr = pos_m2[spjq_pkg::ADDR_W-1:0];
          if (pos_r == spjq_pkg::CNT_W'(1)) begin
            state_nxt = S_PLACE;
          end
        end else begin
          state_nxt = S_PLACE;
        end
      end

      S_PLACE: begin
        wr_en     = 1'b1;
        count_nxt = count_r + spjq_pkg::CNT_W'(1);
        res_nxt   = '{kind: spjq_pkg::KIND_ACK, status: spjq_pkg::STATUS_OK,
                      entry: new_r, last: 1'b1};
        state_nxt = S_RESULT;
      end

      S_RESULT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      // one entry per cycle; address advances only when the word is taken
      S_DOUT: begin
        if (res_ready) begin
          dptr_nxt = dptr_p1;
          rd_addr  = dptr_p1[spjq_pkg::ADDR_W-1:0];
          if (dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    pos_r  <= pos_nxt;
    dptr_r <= dptr_nxt;
    new_r  <= new_nxt;
    res_r  <= res_nxt;
  end

endmodule
